// ===== hw/rtl/sgc_pkg.sv =====
// Shared types, codes and the 5x8 font table for the scaled glyph column generator.
`timescale 1ns / 1ps

package sgc_pkg;

    localparam int FONT_GLYPHS = 43;
    localparam int FONT_COLS   = 5;

    localparam logic [6:0] CODE_SPACE = 7'h20;
    localparam logic [6:0] CODE_BLANK = 7'h3A;
    localparam logic [6:0] CODE_FIRST = 7'h30;

    typedef struct packed {
        logic [6:0] char_code;
        logic [1:0] glyph_scale;
        logic [6:0] start_column;
        logic [2:0] start_page;
    } sgc_cmd_t;

    typedef struct packed {
        logic [2:0] page_addr;
        logic [6:0] column_addr;
        logic [7:0] pixel_byte;
        logic       last_byte;
        logic [6:0] next_column;
    } sgc_beat_t;

    // One row per glyph, font column 0 in the top byte.
    localparam logic [39:0] FONT_ROM [FONT_GLYPHS] = '{
        40'h7CA2928A7C, 40'h0084FE8000, 40'hE49292928C, 40'h448292926C,
        40'h302824FE20, 40'h4E8A8A8A72, 40'h7894929260, 40'h02E2120A06,
        40'h6C9292926C, 40'h0C9292523C, 40'h0000000000, 40'h1C7EFC7E1C,
        40'h1028448200, 40'h2828282828, 40'h8244281000, 40'h4020100804,
        40'h00C0C00000, 40'hF8242224F8, 40'h82FE92926C, 40'h7C82828244,
        40'h82FE82827C, 40'hFE92928282, 40'hFE12120202, 40'h7C82929274,
        40'hFE101010FE, 40'h0082FE8200, 40'h4080827E02, 40'hFE10284482,
        40'hFE80808080, 40'hFE041804FE, 40'hFE040810FE, 40'h7C8282827C,
        40'hFE1212120C, 40'h7C82A242BC, 40'hFE1232528C, 40'h4C92929264,
        40'h0202FE0202, 40'h7E8080807E, 40'h0E30C0300E, 40'hFE403040FE,
        40'hC6281028C6, 40'h0608F00806, 40'hC2A2928A86
    };

    function automatic logic [7:0] font_column(input logic [5:0] glyph,
                                               input logic [2:0] col);
        logic [39:0] row;
        logic [7:0]  dots;
        row = (32'(glyph) < FONT_GLYPHS) ? FONT_ROM[glyph] : 40'h0;
        case (col)
            3'd0:    dots = row[39:32];
            3'd1:    dots = row[31:24];
            3'd2:    dots = row[23:16];
            3'd3:    dots = row[15:8];
            3'd4:    dots = row[7:0];
            default: dots = 8'h00;
        endcase
        return dots;
    endfunction

endpackage

// ===== hw/rtl/sgc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sgc_fill.sv =====
// Font loader: sweeps the glyph table into the font RAM once after reset.
`timescale 1ns / 1ps

module sgc_fill
    import sgc_pkg::*;
#(
    parameter int GLYPHS = 43,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              done
);

    logic [5:0]        glyph_reg, glyph_next;
    logic [2:0]        col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              done_reg, done_next;
    logic              last_word;

    assign last_word = (glyph_reg == 6'(GLYPHS - 1)) && (col_reg == 3'(FONT_COLS - 1));

    always_comb
    begin
        glyph_next = glyph_reg;
        col_next   = col_reg;
        addr_next  = addr_reg;
        done_next  = done_reg;
        if (!done_reg)
        begin
            addr_next = addr_reg + ADDR_W'(1);
            if (last_word)
            begin
                done_next = 1'b1;
            end
            else if (col_reg == 3'(FONT_COLS - 1))
            begin
                col_next   = 3'd0;
                glyph_next = glyph_reg + 6'd1;
            end
            else
            begin
                col_next = col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_reg <= '0;
            col_reg   <= '0;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            glyph_reg <= glyph_next;
            col_reg   <= col_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
        end
    end

    assign wr_en   = !done_reg;
    assign wr_addr = addr_reg;
    assign wr_data = font_column(glyph_reg, col_reg);
    assign done    = done_reg;

endmodule

// ===== hw/rtl/scaled_glyph_column_generator.sv =====
// Top level of the scaled glyph column generator: command decode, beat sequencer, result register.
`timescale 1ns / 1ps

// Draws one character of a 5x8 font, magnified by a scale s of 1 to MAX_SCALE,
// as a run of display bytes. A command is taken at a clock edge with start high
// and busy low; busy then stays high until the character's last beat has been
// issued. Each beat shows on the beat port for exactly one cycle with strobe
// high, and the receiver must take it then: there is no back-pressure. Beats
// come in this order: for each font column, for each page, s copies of the
// column; then one blank column on each page, the last of which carries
// last_byte. A character yields 5*s*s + s beats. A command is accepted in IDLE;
// then, for each of the five font columns, the block reads the font RAM in a
// FETCH state and issues that column's beats in EMIT, one beat per cycle, and
// at last issues the blank beats in BLANK before it returns to IDLE. Beats are
// registered after the internal sequencer in the output register, so the next
// command may be taken while the final beat is still on the port. After reset
// the font RAM is loaded from the built-in table, one column byte per cycle;
// busy is high during the load. Codes other than the digits, the symbols
// 0x3A..0x40 and upper-case letters draw blank, as does a space. A scale of
// zero acts as one, larger scales saturate at MAX_SCALE. Columns wrap modulo
// 128 and pages modulo 8.
module scaled_glyph_column_generator
    import sgc_pkg::*;
#(
    parameter int GLYPH_COUNT = 43,
    parameter int MAX_SCALE   = 3
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  sgc_cmd_t  command,
    output logic      strobe,
    output sgc_beat_t beat
);

    localparam int ROM_GLYPHS = (GLYPH_COUNT < FONT_GLYPHS) ? GLYPH_COUNT : FONT_GLYPHS;
    localparam int RAM_DEPTH  = ROM_GLYPHS * FONT_COLS;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILL  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_BLANK = 5'b10000
    } state_t;

    // Vertical stretch: result bit j of page i takes font bit (8*i + j) / s.
    // Divide by three through a multiply by 11 and shift, exact below 32.
    function automatic logic [7:0] stretch(input logic [7:0] dots,
                                           input logic [1:0] page,
                                           input logic [1:0] s);
        logic [4:0] v;
        logic [9:0] prod;
        logic [2:0] src;
        logic [7:0] r;
        r = 8'h00;
        for (int j = 0; j < 8; j++)
        begin
            v    = {page, 3'(j)};
            prod = 10'(v) * 10'd11;
            case (s)
                2'd2:    src = v[3:1];
                2'd3:    src = prod[7:5];
                default: src = v[2:0];
            endcase
            r[j] = dots[src];
        end
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic [1:0]        scale_reg, scale_next;
    logic              glyph_ok_reg, glyph_ok_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [2:0]        page0_reg, page0_next;
    logic [6:0]        kcol_reg, kcol_next;
    logic [6:0]        next_col_reg, next_col_next;
    logic [2:0]        k_reg, k_next;
    logic [1:0]        i_reg, i_next;
    logic [1:0]        c_reg, c_next;
    logic              strobe_reg, strobe_next;
    sgc_beat_t         beat_reg, beat_next;

    logic              fill_wr_en;
    logic [ADDR_W-1:0] fill_wr_addr;
    logic [7:0]        fill_wr_data;
    logic              fill_done;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Command decode
    logic [1:0] cmd_scale;
    logic [6:0] cmd_code;
    logic [6:0] cmd_idx;
    logic       cmd_ok;
    logic [8:0] cmd_base;

    always_comb
    begin
        if (command.glyph_scale == 2'd0)
        begin
            cmd_scale = 2'd1;
        end
        else if (32'(command.glyph_scale) > MAX_SCALE)
        begin
            cmd_scale = 2'(MAX_SCALE);
        end
        else
        begin
            cmd_scale = command.glyph_scale;
        end
        cmd_code = (command.char_code == CODE_SPACE) ? CODE_BLANK : command.char_code;
        cmd_idx  = cmd_code - CODE_FIRST;
        cmd_ok   = (cmd_code >= CODE_FIRST) && (32'(cmd_idx) < ROM_GLYPHS);
        cmd_base = 9'(cmd_idx[5:0]) * 9'(FONT_COLS);
    end

    sgc_fill #(
        .GLYPHS (ROM_GLYPHS),
        .ADDR_W (ADDR_W)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .done    (fill_done)
    );

    sgc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Fetch the current font column; data lands at the first EMIT cycle and holds.
    assign rd_en   = (state_reg == ST_FETCH);
    assign rd_addr = base_reg + ADDR_W'(k_reg);

    always_comb
    begin
        state_next    = state_reg;
        scale_next    = scale_reg;
        glyph_ok_next = glyph_ok_reg;
        base_next     = base_reg;
        page0_next    = page0_reg;
        kcol_next     = kcol_reg;
        next_col_next = next_col_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        c_next        = c_reg;
        strobe_next   = 1'b0;
        beat_next     = beat_reg;

        case (state_reg)
            ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    scale_next    = cmd_scale;
                    glyph_ok_next = cmd_ok;
                    base_next     = cmd_ok ? ADDR_W'(cmd_base) : '0;
                    page0_next    = command.start_page;
                    kcol_next     = command.start_column;
                    next_col_next = command.start_column
                                    + 7'(7'(cmd_scale) * 7'd5) + 7'd1;
                    k_next        = 3'd0;
                    i_next        = 2'd0;
                    c_next        = 2'd0;
                    state_next    = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // Issue copy c of page i for font column k.
                strobe_next           = 1'b1;
                beat_next.page_addr   = page0_reg + 3'(i_reg);
                beat_next.column_addr = kcol_reg + 7'(c_reg);
                beat_next.pixel_byte  = glyph_ok_reg ? stretch(rd_data, i_reg, scale_reg)
                                                     : 8'h00;
                beat_next.last_byte   = 1'b0;
                beat_next.next_column = next_col_reg;
                if (c_reg == scale_reg - 2'd1)
                begin
                    c_next = 2'd0;
                    if (i_reg == scale_reg - 2'd1)
                    begin
                        // Column done on every page: advance to the next font column.
                        i_next    = 2'd0;
                        kcol_next = kcol_reg + 7'(scale_reg);
                        if (k_reg == 3'(FONT_COLS - 1))
                        begin
                            state_next = ST_BLANK;
                        end
                        else
                        begin
                            k_next     = k_reg + 3'd1;
                            state_next = ST_FETCH;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + 2'd1;
                    end
                end
                else
                begin
                    c_next = c_reg + 2'd1;
                end
            end

            ST_BLANK:
            begin
                // Spacing column after the glyph, one beat per page.
                strobe_next           = 1'b1;
                beat_next.page_addr   = page0_reg + 3'(i_reg);
                beat_next.column_addr = kcol_reg;
                beat_next.pixel_byte  = 8'h00;
                beat_next.last_byte   = (i_reg == scale_reg - 2'd1);
                beat_next.next_column = next_col_reg;
                if (i_reg == scale_reg - 2'd1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next = i_reg + 2'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_FILL;
            strobe_reg <= 1'b0;
            k_reg      <= '0;
            i_reg      <= '0;
            c_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            c_reg      <= c_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        scale_reg    <= scale_next;
        glyph_ok_reg <= glyph_ok_next;
        base_reg     <= base_next;
        page0_reg    <= page0_next;
        kcol_reg     <= kcol_next;
        next_col_reg <= next_col_next;
        beat_reg     <= beat_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign beat   = beat_reg;

`ifndef NO_ASSERTIONS
    // An accepted command holds the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted command");

    // The final beat of a character is always a blank column.
    a_last_blank: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && beat.last_byte |-> beat.pixel_byte == 8'h00)
        else $error("last beat carries pixel data");

    // A character's final beat is never directly followed by another beat.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && beat.last_byte |=> !strobe)
        else $error("beat issued right after a last beat");

    // A font RAM read is always followed by a data beat.
    a_fetch_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |=> state_reg == ST_EMIT)
        else $error("fetch not followed by emit");

    // No beats while the font is being loaded.
    a_fill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |=> !strobe)
        else $error("beat issued during font load");
`endif

endmodule
